// ===== sv/hbs_pkg.sv =====
// shared types, constants and helper functions of the heightmap bilinear sampler
`default_nettype none
package hbs_pkg;

  // height store geometry; the depth is a power of two so the read address wraps by masking
  localparam int STORE_DEPTH  = 65536;
  localparam int ADDR_W       = $clog2(STORE_DEPTH);
  localparam int SAMPLE_W     = 16;
  localparam int WIDX_W       = 16;
  localparam int WEXT_W       = ((ADDR_W > WIDX_W) ? ADDR_W : WIDX_W) + 1;

  // grid geometry
  localparam int MAX_GRID_DIM = 256;
  localparam int IDX_W        = $clog2(MAX_GRID_DIM);
  localparam int DIM_W        = IDX_W + 1;
  localparam int GREG_W       = 9;
  localparam int GEXT_W       = ((GREG_W > DIM_W) ? GREG_W : DIM_W) + 1;
  localparam int ROW_W        = IDX_W + DIM_W;
  localparam int SUM_W        = ((ADDR_W > ROW_W) ? ADDR_W : ROW_W) + 1;

  // fixed-point widths
  localparam int COORD_W      = 32;
  localparam int SCALE_W      = 32;
  localparam int FRAC_W       = 16;
  localparam int PROD_W       = (COORD_W - 1) + SCALE_W;
  localparam int IP_LSB       = 24 + FRAC_W;
  localparam int IP_W         = PROD_W - IP_LSB;
  localparam int ROWB_W       = SAMPLE_W + FRAC_W;
  localparam int COLB_W       = ROWB_W + FRAC_W;
  localparam int OUT_W        = 24;
  localparam int OUT_LSB      = 24;

  localparam logic [SCALE_W-1:0] SCALE_ONE = SCALE_W'(32'h0100_0000);

  typedef enum logic [1:0] {
    CFG_SCALE_X     = 2'd0,
    CFG_SCALE_Y     = 2'd1,
    CFG_GRID_WIDTH  = 2'd2,
    CFG_GRID_HEIGHT = 2'd3
  } cfg_idx_t;

  typedef enum logic {
    MODE_WRITE = 1'b0,
    MODE_QUERY = 1'b1
  } mode_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MULX,
    S_MULY,
    S_LOCY,
    S_ROWS,
    S_RD0,
    S_RD1,
    S_RD2,
    S_RD3,
    S_RDW,
    S_BROW,
    S_BCOL,
    S_DONE
  } state_t;

  // configuration as seen by the datapath
  typedef struct packed {
    logic [SCALE_W-1:0] scale_x;
    logic [SCALE_W-1:0] scale_y;
    logic [DIM_W-1:0]   width;
    logic [IDX_W-1:0]   last_x;
    logic [IDX_W-1:0]   last_y;
  } cfg_t;

  // one located coordinate
  typedef struct packed {
    logic [IDX_W-1:0]  lo;
    logic [IDX_W-1:0]  hi;
    logic [FRAC_W-1:0] frac;
  } loc_t;

  // blend unit controls
  typedef struct packed {
    logic cap_a0;
    logic cap_a1;
    logic cap_b0;
    logic cap_b1;
    logic row_en;
    logic col_en;
  } blend_ctl_t;

  // grid dimension in use: 0 acts as 1, too large acts as the maximum
  function automatic logic [DIM_W-1:0] eff_dim(input logic [GREG_W-1:0] d);
    logic [GEXT_W-1:0] dx;
    dx = GEXT_W'(d);
    if (dx == '0) begin
      eff_dim = DIM_W'(1);
    end else if (dx > GEXT_W'(MAX_GRID_DIM)) begin
      eff_dim = DIM_W'(MAX_GRID_DIM);
    end else begin
      eff_dim = DIM_W'(dx);
    end
  endfunction

  // clamp a scaled grid position into the grid
  function automatic loc_t locate(input logic [PROD_W-1:0] prod, input logic neg,
                                  input logic [IDX_W-1:0] last);
    loc_t             l;
    logic [IP_W-1:0]  ip;
    ip = prod[PROD_W-1:IP_LSB];
    if (neg) begin
      l.lo   = '0;
      l.hi   = (last != '0) ? IDX_W'(1) : '0;
      l.frac = '0;
    end else if (ip >= IP_W'(last)) begin
      l.lo   = last;
      l.hi   = last;
      l.frac = '0;
    end else begin
      l.lo   = ip[IDX_W-1:0];
      l.hi   = ip[IDX_W-1:0] + IDX_W'(1);
      l.frac = prod[IP_LSB-1:IP_LSB-FRAC_W];
    end
    locate = l;
  endfunction

endpackage
`default_nettype wire

// ===== sv/hbs_height_ram.sv =====
// single-port synchronous ram with registered read data
`default_nettype none
module hbs_height_ram #(
  parameter int ADDR_W = 16,
  parameter int DATA_W = 16
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] addr,
  input  wire logic [DATA_W-1:0] wdata,
  output logic      [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [2**ADDR_W];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule
`default_nettype wire

// ===== sv/hbs_cfg_regs.sv =====
// configuration registers and derived grid limits
`default_nettype none
module hbs_cfg_regs (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        wr_en,
  input  wire logic [1:0]  wr_index,
  input  wire logic [31:0] wr_data,
  output hbs_pkg::cfg_t    cfg
);

  logic [hbs_pkg::SCALE_W-1:0] scale_x_r;
  logic [hbs_pkg::SCALE_W-1:0] scale_y_r;
  logic [hbs_pkg::GREG_W-1:0]  grid_width_r;
  logic [hbs_pkg::GREG_W-1:0]  grid_height_r;
  logic [hbs_pkg::DIM_W-1:0]   eff_w;
  logic [hbs_pkg::DIM_W-1:0]   eff_h;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_x_r     <= hbs_pkg::SCALE_ONE;
      scale_y_r     <= hbs_pkg::SCALE_ONE;
      grid_width_r  <= hbs_pkg::GREG_W'(256);
      grid_height_r <= hbs_pkg::GREG_W'(256);
    end else if (wr_en) begin
      case (hbs_pkg::cfg_idx_t'(wr_index))
        hbs_pkg::CFG_SCALE_X:     scale_x_r     <= wr_data[hbs_pkg::SCALE_W-1:0];
        hbs_pkg::CFG_SCALE_Y:     scale_y_r     <= wr_data[hbs_pkg::SCALE_W-1:0];
        hbs_pkg::CFG_GRID_WIDTH:  grid_width_r  <= wr_data[hbs_pkg::GREG_W-1:0];
        hbs_pkg::CFG_GRID_HEIGHT: grid_height_r <= wr_data[hbs_pkg::GREG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    eff_w       = hbs_pkg::eff_dim(grid_width_r);
    eff_h       = hbs_pkg::eff_dim(grid_height_r);
    cfg.scale_x = scale_x_r;
    cfg.scale_y = scale_y_r;
    cfg.width   = eff_w;
    cfg.last_x  = hbs_pkg::IDX_W'(eff_w - hbs_pkg::DIM_W'(1));
    cfg.last_y  = hbs_pkg::IDX_W'(eff_h - hbs_pkg::DIM_W'(1));
  end

endmodule
`default_nettype wire

// ===== sv/hbs_blend.sv =====
// bilinear blend: sample capture, row blends, then column blend
`default_nettype none
module hbs_blend (
  input  wire logic                          clk,
  input  wire hbs_pkg::blend_ctl_t           ctl,
  input  wire logic [hbs_pkg::SAMPLE_W-1:0]  rdata,
  input  wire logic [hbs_pkg::FRAC_W-1:0]    lx,
  input  wire logic [hbs_pkg::FRAC_W-1:0]    ly,
  output logic      [hbs_pkg::OUT_W-1:0]     result
);

  localparam int DS_W = hbs_pkg::SAMPLE_W + 1;
  localparam int RP_W = DS_W + hbs_pkg::FRAC_W + 1;
  localparam int DR_W = hbs_pkg::ROWB_W + 1;
  localparam int CP_W = DR_W + hbs_pkg::FRAC_W + 1;

  logic [hbs_pkg::SAMPLE_W-1:0] a0_r, a1_r, b0_r, b1_r;
  logic [hbs_pkg::ROWB_W-1:0]   ra_r, rb_r;
  logic signed [CP_W-1:0]       pv_r;

  logic signed [DS_W-1:0]       da, db;
  logic signed [RP_W-1:0]       pa, pb, ra_nxt, rb_nxt;
  logic signed [DR_W-1:0]       dr;
  logic signed [CP_W-1:0]       pv_nxt, v;

  // row blends as a0 * 2^16 + (a1 - a0) * lx, exact
  always_comb begin
    da     = signed'(DS_W'(a1_r)) - signed'(DS_W'(a0_r));
    db     = signed'(DS_W'(b1_r)) - signed'(DS_W'(b0_r));
    pa     = RP_W'(da) * signed'(RP_W'(lx));
    pb     = RP_W'(db) * signed'(RP_W'(lx));
    ra_nxt = signed'(RP_W'(a0_r) << hbs_pkg::FRAC_W) + pa;
    rb_nxt = signed'(RP_W'(b0_r) << hbs_pkg::FRAC_W) + pb;
    dr     = signed'(DR_W'(rb_r)) - signed'(DR_W'(ra_r));
    pv_nxt = CP_W'(dr) * signed'(CP_W'(ly));
    v      = signed'(CP_W'(ra_r) << hbs_pkg::FRAC_W) + pv_r;
    result = v[hbs_pkg::OUT_LSB +: hbs_pkg::OUT_W];
  end

  always_ff @(posedge clk) begin
    if (ctl.cap_a0) a0_r <= rdata;
    if (ctl.cap_a1) a1_r <= rdata;
    if (ctl.cap_b0) b0_r <= rdata;
    if (ctl.cap_b1) b1_r <= rdata;
    if (ctl.row_en) begin
      ra_r <= ra_nxt[hbs_pkg::ROWB_W-1:0];
      rb_r <= rb_nxt[hbs_pkg::ROWB_W-1:0];
    end
    if (ctl.col_en) pv_r <= pv_nxt;
  end

endmodule
`default_nettype wire

// ===== sv/heightmap_bilinear_sampler_unit.sv =====
// top level of the heightmap bilinear sampler: sequencer, locate datapath and store
// a write word is taken and stored at the accept edge; busy stays low
// a query word is taken when busy is low; its result strobes after the shared scaling
//   multiplier, locate, row base, four back-to-back reads of the single-port height ram
//   and the blends; queries do not overlap; writes sustain one per cycle while idle
// synchronous active-low reset returns the sequencer to idle and the config to defaults;
//   the height store is not cleared, its entries are undefined until written
// results cannot be held off: out_strobe is high for exactly one cycle per query
`default_nettype none
module heightmap_bilinear_sampler_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic        in_mode,
  input  wire logic [15:0] in_write_index,
  input  wire logic [15:0] in_write_height,
  input  wire logic [31:0] in_query_x,
  input  wire logic [31:0] in_query_y,
  output logic             out_strobe,
  output logic [23:0]      out_height_out,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);

  hbs_pkg::state_t     state_r, state_nxt;
  hbs_pkg::cfg_t       cfg;
  hbs_pkg::blend_ctl_t bctl;

  // latched query word
  logic [hbs_pkg::COORD_W-1:0] qx_r, qy_r;
  // shared scaling multiplier output
  logic [hbs_pkg::PROD_W-1:0]  prod_r, prod_nxt;
  hbs_pkg::loc_t               locx_r, locy_r;
  // row base addresses of the lower and upper rows
  logic [hbs_pkg::ROW_W-1:0]   rowf_r, rowc_r;

  logic                        out_strobe_r;
  logic [hbs_pkg::OUT_W-1:0]   out_height_r;
  logic [hbs_pkg::OUT_W-1:0]   blend_result;

  logic                        accept;
  logic                        wr_ok;
  logic [hbs_pkg::WEXT_W-1:0]  widx_ext;
  logic                        ram_we;
  logic [hbs_pkg::ADDR_W-1:0]  ram_addr;
  logic [hbs_pkg::SAMPLE_W-1:0] ram_rdata;
  logic [hbs_pkg::IDX_W-1:0]   rd_col;
  logic [hbs_pkg::ROW_W-1:0]   rd_row;
  logic [hbs_pkg::SUM_W-1:0]   rd_sum;
  logic [hbs_pkg::COORD_W-2:0] mul_a;
  logic [hbs_pkg::SCALE_W-1:0] mul_b;

  // config writes must happen only while idle; the block itself does not enforce this
  assign cfg_ready = 1'b1;

  hbs_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid & cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  assign busy   = (state_r != hbs_pkg::S_IDLE);
  assign accept = start & ~busy;

  // write words go straight into the ram at the accept edge
  always_comb begin
    widx_ext = hbs_pkg::WEXT_W'(in_write_index);
    wr_ok    = (widx_ext < hbs_pkg::WEXT_W'(hbs_pkg::STORE_DEPTH));
    ram_we   = accept & (hbs_pkg::mode_t'(in_mode) == hbs_pkg::MODE_WRITE) & wr_ok;
  end

  // read address: column plus row base, wrapped to the store size; write index while idle
  always_comb begin
    rd_col = locx_r.lo;
    rd_row = rowf_r;
    case (state_r)
      hbs_pkg::S_RD1: begin
        rd_col = locx_r.hi;
      end
      hbs_pkg::S_RD2: begin
        rd_row = rowc_r;
      end
      hbs_pkg::S_RD3: begin
        rd_col = locx_r.hi;
        rd_row = rowc_r;
      end
      default: ;
    endcase
    rd_sum = hbs_pkg::SUM_W'(rd_col) + hbs_pkg::SUM_W'(rd_row);
    if (busy) begin
      ram_addr = rd_sum[hbs_pkg::ADDR_W-1:0];
    end else begin
      ram_addr = widx_ext[hbs_pkg::ADDR_W-1:0];
    end
  end

  hbs_height_ram #(
    .ADDR_W (hbs_pkg::ADDR_W),
    .DATA_W (hbs_pkg::SAMPLE_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (in_write_height),
    .rdata (ram_rdata)
  );

  // one multiplier scales x, then y; negative coordinates are resolved by locate
  always_comb begin
    if (state_r == hbs_pkg::S_MULX) begin
      mul_a = qx_r[hbs_pkg::COORD_W-2:0];
      mul_b = cfg.scale_x;
    end else begin
      mul_a = qy_r[hbs_pkg::COORD_W-2:0];
      mul_b = cfg.scale_y;
    end
    prod_nxt = hbs_pkg::PROD_W'(mul_a) * hbs_pkg::PROD_W'(mul_b);
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= hbs_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    bctl      = '0;
    case (state_r)
      hbs_pkg::S_IDLE: begin
        if (accept && hbs_pkg::mode_t'(in_mode) == hbs_pkg::MODE_QUERY) begin
          state_nxt = hbs_pkg::S_MULX;
        end
      end
      hbs_pkg::S_MULX: state_nxt = hbs_pkg::S_MULY;
      hbs_pkg::S_MULY: state_nxt = hbs_pkg::S_LOCY;
      hbs_pkg::S_LOCY: state_nxt = hbs_pkg::S_ROWS;
      hbs_pkg::S_ROWS: state_nxt = hbs_pkg::S_RD0;
      hbs_pkg::S_RD0:  state_nxt = hbs_pkg::S_RD1;
      hbs_pkg::S_RD1: begin
        bctl.cap_a0 = 1'b1;
        state_nxt   = hbs_pkg::S_RD2;
      end
      hbs_pkg::S_RD2: begin
        bctl.cap_a1 = 1'b1;
        state_nxt   = hbs_pkg::S_RD3;
      end
      hbs_pkg::S_RD3: begin
        bctl.cap_b0 = 1'b1;
        state_nxt   = hbs_pkg::S_RDW;
      end
      hbs_pkg::S_RDW: begin
        bctl.cap_b1 = 1'b1;
        state_nxt   = hbs_pkg::S_BROW;
      end
      hbs_pkg::S_BROW: begin
        bctl.row_en = 1'b1;
        state_nxt   = hbs_pkg::S_BCOL;
      end
      hbs_pkg::S_BCOL: begin
        bctl.col_en = 1'b1;
        state_nxt   = hbs_pkg::S_DONE;
      end
      hbs_pkg::S_DONE: state_nxt = hbs_pkg::S_IDLE;
      default:         state_nxt = hbs_pkg::S_IDLE;
    endcase
  end

  // locate datapath: product, then clamp, then row base
  always_ff @(posedge clk) begin
    if (accept) begin
      qx_r <= in_query_x;
      qy_r <= in_query_y;
    end
    if (state_r == hbs_pkg::S_MULX || state_r == hbs_pkg::S_MULY) begin
      prod_r <= prod_nxt;
    end
    if (state_r == hbs_pkg::S_MULY) begin
      locx_r <= hbs_pkg::locate(prod_r, qx_r[hbs_pkg::COORD_W-1], cfg.last_x);
    end
    if (state_r == hbs_pkg::S_LOCY) begin
      locy_r <= hbs_pkg::locate(prod_r, qy_r[hbs_pkg::COORD_W-1], cfg.last_y);
    end
    if (state_r == hbs_pkg::S_ROWS) begin
      rowf_r <= hbs_pkg::ROW_W'(locy_r.lo) * hbs_pkg::ROW_W'(cfg.width);
      rowc_r <= hbs_pkg::ROW_W'(locy_r.hi) * hbs_pkg::ROW_W'(cfg.width);
    end
  end

  hbs_blend u_blend (
    .clk    (clk),
    .ctl    (bctl),
    .rdata  (ram_rdata),
    .lx     (locx_r.frac),
    .ly     (locy_r.frac),
    .result (blend_result)
  );

  // result register: one-cycle strobe, receiver cannot stall
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= (state_r == hbs_pkg::S_DONE);
    end
    if (state_r == hbs_pkg::S_DONE) begin
      out_height_r <= blend_result;
    end
  end

  assign out_strobe     = out_strobe_r;
  assign out_height_out = out_height_r;

endmodule
`default_nettype wire
